// File: rtl/json_key_value_extractor_top_assert.svh
// ---------------------------------------------------------------------------
// JSON key/value extractor assertion macros
// Shorthand for the concurrent checks used inside the extractor modules.
// Each macro expects signals named clk and rst in the enclosing module.
// ---------------------------------------------------------------------------
`ifndef JSON_KEY_VALUE_EXTRACTOR_TOP_ASSERT_SVH
`define JSON_KEY_VALUE_EXTRACTOR_TOP_ASSERT_SVH

// Condition holds at every clock edge outside reset
`define JKV_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define JKV_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define JKV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/jkv_pkg.sv
// ---------------------------------------------------------------------------
// JSON key/value extractor package
// Shared constants, character codes and item types for the extractor.
// ---------------------------------------------------------------------------
package jkv_pkg;

  // Key window geometry
  localparam int MAX_KEY_CHARS = 8;
  localparam int WINDOW        = MAX_KEY_CHARS + 2;
  localparam int KEY_TEXT_W    = 8 * MAX_KEY_CHARS;
  localparam int KEY_LEN_W     = 4;
  localparam int KEY_IDX_W     = $clog2(MAX_KEY_CHARS);

  // Configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_TEXT   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LENGTH = 1'b1;

  // Character codes
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;

  // Outcome codes
  localparam logic [1:0] OUT_STRING  = 2'd0;
  localparam logic [1:0] OUT_BARE    = 2'd1;
  localparam logic [1:0] OUT_NOT_KEY = 2'd2;
  localparam logic [1:0] OUT_NOCOLON = 2'd3;

  // Output queue geometry
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_COUNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [FIFO_COUNT_W-1:0] FIFO_FULL_COUNT = FIFO_COUNT_W'(FIFO_DEPTH);

  // One result item
  typedef struct packed {
    logic [7:0] value_byte;
    logic       is_status;
    logic [1:0] outcome;
    logic       run_end;
  } result_t;

  // All results caused by one input item; the first is always present
  typedef struct packed {
    logic    second_valid;
    result_t first;
    result_t second;
  } pair_t;

endpackage

// File: rtl/json_key_value_extractor_top.sv
// Each accepted item's results are queued and offered once older entries have gone.
// One item per cycle unless the result queue is full; cells and phase are registered.
// An item that causes two results hands them to the output one after the other.
// The four-entry result queue sets how far the input runs ahead of a stalled output.
// Reset (rst, synchronous, active high) clears the phase, the byte window,
// the queue and both key registers.
// ---------------------------------------------------------------------------
// JSON key/value extractor top level
// Finds a quoted key in a byte stream through a chain of window cells and
// extracts the value that follows, with one status item per document.
// ---------------------------------------------------------------------------
module json_key_value_extractor_top (
  input  logic                            clk,
  input  logic                            rst,
  // tdata: text_byte[7:0]
  input  logic [7:0]                      s_axis_tdata,
  // tlast: document_end
  input  logic                            s_axis_tlast,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: value_byte[7:0]
  output logic [7:0]                      m_axis_tdata,
  // tuser: is_status[0], outcome[2:1]
  output logic [2:0]                      m_axis_tuser,
  // tlast: run_end
  output logic                            m_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_we,
  input  logic [jkv_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [jkv_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import jkv_pkg::*;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_PRECOLON,
    PH_POSTCOLON,
    PH_STRING,
    PH_BARE,
    PH_DONE,
    PH_ESCAPE
  } phase_t;

  phase_t phase;
  phase_t phase_take;
  phase_t phase_close_in;
  logic   text_closed;

  logic [KEY_TEXT_W-1:0] key_text;
  logic [KEY_LEN_W-1:0]  key_length;
  logic [KEY_LEN_W-1:0]  key_len_eff;

  logic [7:0]        win_in   [WINDOW];
  logic [7:0]        win_out  [WINDOW];
  logic [7:0]        win_pat  [WINDOW];
  logic [WINDOW-1:0] win_care;
  logic [WINDOW-1:0] win_hit;
  logic              key_match;

  logic       accept;
  logic [7:0] byte_in;
  logic       doc_end;
  logic       is_nul;
  logic       active;
  logic       shift;
  logic       close_en;

  logic    take_v;
  result_t take_r;
  logic    c0_v;
  result_t c0_r;
  logic    c1_v;
  result_t c1_r;
  pair_t   pair;
  logic    pair_any;
  logic    q_full;
  result_t m_item;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign byte_in = s_axis_tdata;
  assign doc_end = s_axis_tlast;
  assign is_nul  = (byte_in == CH_NUL);
  assign active  = accept && !text_closed;
  assign shift   = active && !is_nul && (phase == PH_SEARCH);
  assign close_en = !text_closed && (is_nul || doc_end);

  // Hold the key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_text   <= '0;
      key_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KEY_TEXT:   key_text   <= cfg_wdata[KEY_TEXT_W-1:0];
        REG_KEY_LENGTH: key_length <= cfg_wdata[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp an oversized key length
  assign key_len_eff = (key_length > KEY_LEN_W'(MAX_KEY_CHARS)) ?
                       KEY_LEN_W'(MAX_KEY_CHARS) : key_length;

  // Pattern per cell: quote, key reversed, quote, then don't care
  always_comb begin
    logic [KEY_LEN_W-1:0] kidx;
    for (int j = 0; j < WINDOW; j++) begin
      kidx        = key_len_eff - KEY_LEN_W'(j);
      win_pat[j]  = CH_QUOTE;
      win_care[j] = 1'b0;
      if (j == 0) begin
        win_care[j] = 1'b1;
      end else if (KEY_LEN_W'(j) <= key_len_eff) begin
        win_pat[j]  = key_text[kidx[KEY_IDX_W-1:0]*8 +: 8];
        win_care[j] = 1'b1;
      end else if (KEY_LEN_W'(j) == key_len_eff + 1'b1) begin
        win_care[j] = 1'b1;
      end
    end
  end

  // Row of window cells, newest byte at cell zero
  genvar g;
  generate
    for (g = 0; g < WINDOW; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign win_in[g] = byte_in;
      end else begin : g_link
        assign win_in[g] = win_out[g-1];
      end
      jkv_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .clear        (accept && doc_end),
        .shift        (shift),
        .din          (win_in[g]),
        .pattern_char (win_pat[g]),
        .care         (win_care[g]),
        .dout         (win_out[g]),
        .hit          (win_hit[g])
      );
    end
  endgenerate

  assign key_match = &win_hit;

  // Process one nonzero byte
  always_comb begin
    take_v     = 1'b0;
    take_r     = '{value_byte: byte_in, is_status: 1'b0, outcome: OUT_STRING,
                   run_end: 1'b0};
    phase_take = phase;
    unique case (phase)
      PH_SEARCH: begin
        if (key_match) begin
          phase_take = PH_PRECOLON;
        end
      end
      PH_PRECOLON: begin
        if (byte_in == CH_COLON) begin
          phase_take = PH_POSTCOLON;
        end else if (byte_in != CH_SPACE && byte_in != CH_TAB) begin
          take_v     = 1'b1;
          take_r     = '{value_byte: CH_NUL, is_status: 1'b1, outcome: OUT_NOCOLON,
                         run_end: 1'b0};
          phase_take = PH_DONE;
        end
      end
      PH_POSTCOLON: begin
        if (byte_in == CH_SPACE || byte_in == CH_TAB) begin
          phase_take = PH_POSTCOLON;
        end else if (byte_in == CH_QUOTE) begin
          phase_take = PH_STRING;
        end else if (byte_in == CH_COMMA || byte_in == CH_RBRACE) begin
          take_v     = 1'b1;
          take_r     = '{value_byte: CH_NUL, is_status: 1'b1, outcome: OUT_BARE,
                         run_end: 1'b0};
          phase_take = PH_DONE;
        end else begin
          take_v     = 1'b1;
          phase_take = PH_BARE;
        end
      end
      PH_STRING: begin
        if (byte_in == CH_QUOTE) begin
          take_v     = 1'b1;
          take_r     = '{value_byte: CH_NUL, is_status: 1'b1, outcome: OUT_STRING,
                         run_end: 1'b0};
          phase_take = PH_DONE;
        end else if (byte_in == CH_BACKSLASH) begin
          phase_take = PH_ESCAPE;
        end else begin
          take_v = 1'b1;
        end
      end
      PH_ESCAPE: begin
        take_v     = 1'b1;
        phase_take = PH_STRING;
        if (byte_in == CH_N) begin
          take_r.value_byte = CH_LF;
        end else if (byte_in == CH_R) begin
          take_r.value_byte = CH_CR;
        end else if (byte_in == CH_T) begin
          take_r.value_byte = CH_TAB;
        end
      end
      PH_BARE: begin
        if (byte_in == CH_COMMA || byte_in == CH_RBRACE || byte_in == CH_SPACE) begin
          take_v     = 1'b1;
          take_r     = '{value_byte: CH_NUL, is_status: 1'b1, outcome: OUT_BARE,
                         run_end: 1'b0};
          phase_take = PH_DONE;
        end else begin
          take_v = 1'b1;
        end
      end
      PH_DONE: begin
        phase_take = PH_DONE;
      end
      default: begin
        phase_take = PH_DONE;
      end
    endcase
  end

  // Give the pending outcome when the text closes
  assign phase_close_in = is_nul ? phase : phase_take;

  always_comb begin
    c0_v = 1'b1;
    c0_r = '{value_byte: CH_NUL, is_status: 1'b1, outcome: OUT_STRING, run_end: 1'b0};
    c1_v = 1'b0;
    c1_r = '{value_byte: CH_NUL, is_status: 1'b1, outcome: OUT_STRING, run_end: 1'b1};
    unique case (phase_close_in)
      PH_SEARCH:    c0_r.outcome = OUT_NOT_KEY;
      PH_PRECOLON:  c0_r.outcome = OUT_NOCOLON;
      PH_POSTCOLON: c0_r.outcome = OUT_BARE;
      PH_STRING:    c0_r.outcome = OUT_STRING;
      PH_BARE:      c0_r.outcome = OUT_BARE;
      PH_ESCAPE: begin
        // dangling backslash goes out as a literal
        c0_r = '{value_byte: CH_BACKSLASH, is_status: 1'b0, outcome: OUT_STRING,
                 run_end: 1'b0};
        c1_v = 1'b1;
      end
      PH_DONE:      c0_v = 1'b0;
      default:      c0_v = 1'b0;
    endcase
  end

  // Merge the take and close results into one queue entry
  always_comb begin
    logic t_v;
    logic cl0_v;
    logic cl1_v;
    t_v   = !is_nul && take_v;
    cl0_v = close_en && c0_v;
    cl1_v = close_en && c1_v;
    pair  = '0;
    if (t_v) begin
      pair.first        = take_r;
      pair.second       = c0_r;
      pair.second_valid = cl0_v;
    end else begin
      pair.first        = c0_r;
      pair.second       = c1_r;
      pair.second_valid = cl1_v;
    end
    pair.first.run_end  = !pair.second_valid;
    pair.second.run_end = 1'b1;
    pair_any = t_v || cl0_v;
  end

  // Hold phase and the closed flag
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SEARCH;
      text_closed <= 1'b0;
    end else if (accept) begin
      if (doc_end) begin
        phase       <= PH_SEARCH;
        text_closed <= 1'b0;
      end else if (!text_closed) begin
        if (is_nul) begin
          phase       <= PH_DONE;
          text_closed <= 1'b1;
        end else begin
          phase <= phase_take;
        end
      end
    end
  end

  jkv_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (active && pair_any),
    .push_data (pair),
    .full      (q_full),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_item    (m_item)
  );

  assign s_axis_tready = !q_full;
  assign m_axis_tdata  = m_item.value_byte;
  assign m_axis_tuser  = {m_item.outcome, m_item.is_status};
  assign m_axis_tlast  = m_item.run_end;

endmodule

// File: rtl/jkv_cell.sv
// ---------------------------------------------------------------------------
// Key window cell
// Holds one byte of the recent-byte window, passes it on to the next cell
// on each shift and compares the byte it is about to take with its pattern.
// ---------------------------------------------------------------------------
module jkv_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       clear,
  input  logic       shift,
  input  logic [7:0] din,
  input  logic [7:0] pattern_char,
  input  logic       care,
  output logic [7:0] dout,
  output logic       hit
);

  import jkv_pkg::*;

  logic [7:0] held;

  // Hold the byte, clear it at document end
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held <= CH_NUL;
    end else if (shift) begin
      held <= din;
    end
  end

  // Compare the incoming byte, so a hit refers to the window after the shift
  assign hit  = !care || (din == pattern_char);
  assign dout = held;

endmodule

// File: rtl/jkv_out_fifo.sv
// ---------------------------------------------------------------------------
// Result queue
// Stores the results of one input item per entry and hands them out one
// item at a time, so the input side runs on while the output stalls, until full.
// ---------------------------------------------------------------------------
`include "json_key_value_extractor_top_assert.svh"

module jkv_out_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jkv_pkg::pair_t  push_data,
  output logic            full,
  output logic            m_valid,
  input  logic            m_ready,
  output jkv_pkg::result_t m_item
);

  import jkv_pkg::*;

  pair_t                   mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_COUNT_W-1:0] count;
  logic [FIFO_COUNT_W-1:0] count_next;
  logic                    half;
  pair_t                   head;
  logic                    pop_item;
  logic                    entry_done;

  assign head       = mem[rd_ptr];
  assign m_valid    = (count != '0);
  assign m_item     = half ? head.second : head.first;
  assign full       = (count == FIFO_FULL_COUNT);
  assign pop_item   = m_valid && m_ready;
  assign entry_done = pop_item && (half || !head.second_valid);

  // Write the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_comb begin
    count_next = count;
    if (push && !entry_done) begin
      count_next = count + 1'b1;
    end else if (!push && entry_done) begin
      count_next = count - 1'b1;
    end
  end

  // Advance pointers, count and the half select
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      half   <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (entry_done) begin
        rd_ptr <= rd_ptr + 1'b1;
        half   <= 1'b0;
      end else if (pop_item) begin
        half <= 1'b1;
      end
    end
  end

  `JKV_ASSERT_HOLDS(a_count_range, count <= FIFO_FULL_COUNT, "result queue count out of range")
  `JKV_ASSERT_IMPLIES(a_no_push_full, push, !full, "item pushed into a full result queue")
  `JKV_ASSERT_NEXT(a_second_follows, pop_item && !half && head.second_valid, half && m_valid, "second result of an item lost")
  `JKV_ASSERT_IMPLIES(a_second_is_status, m_valid && half, m_item.is_status && m_item.run_end, "second result is not a closing status")

endmodule

// File: bench/tb_json_key_value_extractor_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the JSON key/value extractor
// Streams JSON-like documents into the extractor under several key settings,
// predicts every value and status item in a behavioural model of the scanner
// and compares each output item field by field, with random gaps on both sides.
// ---------------------------------------------------------------------------
module tb_json_key_value_extractor_top;
  import jkv_pkg::*;

  // Scanner position within one document
  typedef enum logic [2:0] {
    SCAN_KEY, SCAN_COLON, SCAN_VALUE, IN_STRING, IN_BARE, SCAN_DONE, IN_ESCAPE
  } scan_t;

  // One row of the directed table
  typedef struct packed {
    logic [7:0] chr;
    logic       last;
    logic       typed;
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } text_row_t;

  localparam logic [1:0] NO_OUTCOME = 2'd0;
  localparam result_t    NO_RESULT  = '0;
  localparam int         PHASE_ITEMS = 220;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [7:0]            s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            m_axis_tdata;
  logic [2:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_KEY_TEXT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Scanner model state and key copy
  scan_t                 scan = SCAN_KEY;
  logic [7:0]            recent_text [0:WINDOW-1];
  logic                  text_closed = 1'b0;
  logic [63:0]           key_text_q = '0;
  logic [3:0]            key_len_q = '0;

  result_t               step_results [$];
  result_t               expected_results [$];
  text_row_t             directed_rows [$];
  logic [7:0]            doc_bytes [$];
  int unsigned           idle_pct = 36;
  int unsigned           items_sent = 0;
  int unsigned           errors = 0;

  json_key_value_extractor_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void emit_result(input logic [7:0] b, input logic st,
                                      input logic [1:0] oc);
    step_results.push_back({b, st, oc, 1'b0});
  endfunction

  // Give the pending outcome when the text closes
  function automatic void close_text();
    case (scan)
      SCAN_KEY:   emit_result(CH_NUL, 1'b1, OUT_NOT_KEY);
      SCAN_COLON: emit_result(CH_NUL, 1'b1, OUT_NOCOLON);
      SCAN_VALUE: emit_result(CH_NUL, 1'b1, OUT_BARE);
      IN_STRING:  emit_result(CH_NUL, 1'b1, OUT_STRING);
      IN_ESCAPE: begin
        emit_result(CH_BACKSLASH, 1'b0, NO_OUTCOME);
        emit_result(CH_NUL, 1'b1, OUT_STRING);
      end
      IN_BARE:    emit_result(CH_NUL, 1'b1, OUT_BARE);
      default: ;
    endcase
    scan = SCAN_DONE;
  endfunction

  function automatic void reset_document();
    int unsigned i;
    scan = SCAN_KEY;
    for (i = 0; i < WINDOW; i++) recent_text[i] = CH_NUL;
    text_closed = 1'b0;
  endfunction

  // Work out the items one text byte causes
  function automatic void predict_text(input logic [7:0] b, input logic last);
    int unsigned klen;
    int unsigned i;
    logic        hit;
    result_t     tail;
    step_results.delete();
    if (!text_closed) begin
      if (b == CH_NUL) begin
        close_text();
        text_closed = 1'b1;
      end else begin
        case (scan)
          SCAN_KEY: begin
            for (i = WINDOW - 1; i > 0; i--) recent_text[i] = recent_text[i - 1];
            recent_text[0] = b;
            klen = (key_len_q > MAX_KEY_CHARS) ? MAX_KEY_CHARS : key_len_q;
            hit = (recent_text[0] == CH_QUOTE) && (recent_text[klen + 1] == CH_QUOTE);
            for (i = 0; i < klen; i++)
              if (recent_text[klen - i] != key_text_q[8 * i +: 8]) hit = 1'b0;
            if (hit) scan = SCAN_COLON;
          end
          SCAN_COLON: begin
            if (b == CH_COLON) begin
              scan = SCAN_VALUE;
            end else if (b != CH_SPACE && b != CH_TAB) begin
              emit_result(CH_NUL, 1'b1, OUT_NOCOLON);
              scan = SCAN_DONE;
            end
          end
          SCAN_VALUE: begin
            if (b == CH_QUOTE) begin
              scan = IN_STRING;
            end else if (b == CH_COMMA || b == CH_RBRACE) begin
              emit_result(CH_NUL, 1'b1, OUT_BARE);
              scan = SCAN_DONE;
            end else if (b != CH_SPACE && b != CH_TAB) begin
              emit_result(b, 1'b0, NO_OUTCOME);
              scan = IN_BARE;
            end
          end
          IN_STRING: begin
            if (b == CH_QUOTE) begin
              emit_result(CH_NUL, 1'b1, OUT_STRING);
              scan = SCAN_DONE;
            end else if (b == CH_BACKSLASH) begin
              scan = IN_ESCAPE;
            end else begin
              emit_result(b, 1'b0, NO_OUTCOME);
            end
          end
          IN_ESCAPE: begin
            case (b)
              CH_N:    emit_result(CH_LF, 1'b0, NO_OUTCOME);
              CH_R:    emit_result(CH_CR, 1'b0, NO_OUTCOME);
              CH_T:    emit_result(CH_TAB, 1'b0, NO_OUTCOME);
              default: emit_result(b, 1'b0, NO_OUTCOME);
            endcase
            scan = IN_STRING;
          end
          IN_BARE: begin
            if (b == CH_COMMA || b == CH_RBRACE || b == CH_SPACE) begin
              emit_result(CH_NUL, 1'b1, OUT_BARE);
              scan = SCAN_DONE;
            end else begin
              emit_result(b, 1'b0, NO_OUTCOME);
            end
          end
          default: ;
        endcase
        if (last) close_text();
      end
    end
    // Mark the last item of this byte
    if (step_results.size() > 0) begin
      tail = step_results.pop_back();
      tail.run_end = 1'b1;
      step_results.push_back(tail);
    end
    if (last) reset_document();
  endfunction

  function automatic result_t status_item(input logic [1:0] oc);
    return {CH_NUL, 1'b1, oc, 1'b1};
  endfunction

  function automatic void add_row(input logic [7:0] chr, input logic last,
                                  input logic typed, input logic [1:0] count,
                                  input result_t first, input result_t second);
    directed_rows.push_back({chr, last, typed, count, first, second});
  endfunction

  // Bias towards the bytes the scanner reacts to
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10)      return CH_QUOTE;
    else if (r < 16) return CH_BACKSLASH;
    else if (r < 22) return CH_SPACE;
    else if (r < 26) return CH_TAB;
    else if (r < 32) return CH_COLON;
    else if (r < 37) return CH_COMMA;
    else if (r < 42) return CH_RBRACE;
    else if (r < 46) return CH_N;
    else if (r < 49) return CH_R;
    else if (r < 52) return CH_T;
    else             return 8'($urandom_range(1, 255));
  endfunction

  // Offer one text item and record what it should cause once accepted
  task automatic feed_text(input logic [7:0] b, input logic last, input logic typed,
                           input logic [1:0] count, input result_t first,
                           input result_t second);
    int unsigned i;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_text(b, last);
    if (typed) begin
      if (count > 0) expected_results.push_back(first);
      if (count > 1) expected_results.push_back(second);
    end else begin
      for (i = 0; i < step_results.size(); i++) expected_results.push_back(step_results[i]);
    end
    items_sent++;
  endtask

  // Hold the input quiet until every expected item is out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_key(input logic [63:0] text, input logic [3:0] len);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_KEY_TEXT;
    cfg_wdata <= text;
    @(posedge clk);
    cfg_addr  <= REG_KEY_LENGTH;
    cfg_wdata <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_we    <= 1'b0;
    key_text_q = text;
    key_len_q  = len;
  endtask

  // Build one document: mostly key, colon and value, some noise and cut-offs
  task automatic build_document();
    int unsigned klen;
    int unsigned n;
    int unsigned i;
    int unsigned pick;
    logic [7:0]  c;
    doc_bytes.delete();
    klen = (key_len_q > MAX_KEY_CHARS) ? MAX_KEY_CHARS : key_len_q;
    if ($urandom_range(0, 99) < 8) begin
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++)
        doc_bytes.push_back($urandom_range(0, 1) ? pick_char() : 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) doc_bytes.push_back(pick_char());
      doc_bytes.push_back(CH_QUOTE);
      if ($urandom_range(0, 99) < 90) begin
        for (i = 0; i < klen; i++) doc_bytes.push_back(key_text_q[8 * i +: 8]);
        doc_bytes.push_back(CH_QUOTE);
      end else begin
        n = $urandom_range(0, klen);
        for (i = 0; i < n; i++) doc_bytes.push_back(key_text_q[8 * i +: 8]);
        doc_bytes.push_back(pick_char());
      end
      repeat ($urandom_range(0, 2)) doc_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      doc_bytes.push_back(($urandom_range(0, 99) < 88) ? CH_COLON : pick_char());
      repeat ($urandom_range(0, 2)) doc_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // quoted string with escapes
        doc_bytes.push_back(CH_QUOTE);
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) begin
            doc_bytes.push_back(CH_BACKSLASH);
            case ($urandom_range(0, 5))
              0:       c = CH_N;
              1:       c = CH_R;
              2:       c = CH_T;
              3:       c = CH_QUOTE;
              4:       c = CH_BACKSLASH;
              default: c = 8'($urandom_range(1, 255));
            endcase
          end else begin
            c = 8'($urandom_range(1, 255));
            if (c == CH_QUOTE || c == CH_BACKSLASH) c = "a";
          end
          doc_bytes.push_back(c);
        end
        if ($urandom_range(0, 9) != 0) doc_bytes.push_back(CH_QUOTE);
      end else if (pick < 85) begin
        // bare token
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
          c = 8'($urandom_range(1, 255));
          if (c == CH_COMMA || c == CH_RBRACE || c == CH_SPACE) c = "-";
          if (i == 0 && c == CH_QUOTE) c = "7";
          doc_bytes.push_back(c);
        end
        case ($urandom_range(0, 3))
          0: doc_bytes.push_back(CH_COMMA);
          1: doc_bytes.push_back(CH_RBRACE);
          2: doc_bytes.push_back(CH_SPACE);
          default: ;
        endcase
      end else begin
        doc_bytes.push_back($urandom_range(0, 1) ? CH_COMMA : CH_RBRACE);
      end
      repeat ($urandom_range(0, 3)) doc_bytes.push_back(pick_char());
    end
    // Cut the document short to close the text in any phase
    if ($urandom_range(0, 99) < 12) begin
      n = $urandom_range(1, doc_bytes.size());
      while (doc_bytes.size() > n) doc_bytes.delete(doc_bytes.size() - 1);
    end
    if ($urandom_range(0, 99) < 10) begin
      doc_bytes.push_back(CH_NUL);
      repeat ($urandom_range(0, 2)) doc_bytes.push_back(pick_char());
    end
  endtask

  task automatic run_phase(input logic [63:0] text, input logic [3:0] len,
                           input int unsigned idle);
    int unsigned target;
    int unsigned i;
    drain_results();
    set_key(text, len);
    idle_pct = idle;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) begin
      build_document();
      for (i = 0; i < doc_bytes.size(); i++)
        feed_text(doc_bytes[i], i == doc_bytes.size() - 1, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    end
  endtask

  // Compare each output item with the oldest expectation; stall at random
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected item: value_byte %0h tuser %0h tlast %0b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata !== want.value_byte) begin
          $error("value_byte: expected %0h, actual %0h", want.value_byte, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser[0] !== want.is_status) begin
          $error("is_status: expected %0b, actual %0b", want.is_status, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[2:1] !== want.outcome) begin
          $error("outcome: expected %0d, actual %0d", want.outcome, m_axis_tuser[2:1]);
          errors++;
        end
        if (m_axis_tlast !== want.run_end) begin
          $error("run_end: expected %0b, actual %0b", want.run_end, m_axis_tlast);
          errors++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // Stimulus: reset, directed table, then random phases
  initial begin : stimulus
    int unsigned i;
    reset_document();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_key({56'd0, 8'("k")}, 4'd1);

    // zero byte closes the text while searching; the rest is ignored
    add_row(CH_NUL, 1'b0, 1'b1, 2'd1, status_item(OUT_NOT_KEY), NO_RESULT);
    add_row(8'hFF, 1'b1, 1'b1, 2'd0, NO_RESULT, NO_RESULT);
    // dangling backslash at document end
    add_row(CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row("k", 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row(CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row(CH_COLON, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row(CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row(CH_BACKSLASH, 1'b1, 1'b1, 2'd2, {CH_BACKSLASH, 1'b0, NO_OUTCOME, 1'b0},
            status_item(OUT_STRING));
    // key followed by something other than a colon; later bytes ignored
    add_row(CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row("k", 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row(CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row(CH_TAB, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row("x", 1'b0, 1'b1, 2'd1, status_item(OUT_NOCOLON), NO_RESULT);
    add_row("y", 1'b1, 1'b1, 2'd0, NO_RESULT, NO_RESULT);
    // empty bare value, then a zero byte ending the document
    add_row(CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row("k", 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row(CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row(CH_COLON, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row(CH_COMMA, 1'b0, 1'b1, 2'd1, status_item(OUT_BARE), NO_RESULT);
    add_row(CH_NUL, 1'b1, 1'b1, 2'd0, NO_RESULT, NO_RESULT);
    // bare value of the top byte, closed by a brace
    add_row(CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row("k", 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row(CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row(CH_COLON, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row(8'hFF, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
    add_row(CH_RBRACE, 1'b1, 1'b1, 2'd1, status_item(OUT_BARE), NO_RESULT);

    for (i = 0; i < directed_rows.size(); i++)
      feed_text(directed_rows[i].chr, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].count, directed_rows[i].first, directed_rows[i].second);

    // "name"; all-ones key of full length; oversize length with no idling;
    // zero byte inside the key; empty key; random key
    run_phase(64'h0000_0000_656D_616E, 4'd4, 36);
    run_phase(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 36);
    run_phase(64'h6E6F_6974_6163_6F6C, 4'd15, 0);
    run_phase(64'h0000_0000_0062_0061, 4'd3, 36);
    run_phase({$urandom, $urandom}, 4'd0, 36);
    run_phase({$urandom, $urandom}, 4'($urandom_range(1, 7)), 36);

    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: json_key_value_extractor_top.f
+incdir+rtl
rtl/jkv_pkg.sv
rtl/jkv_cell.sv
rtl/jkv_out_fifo.sv
rtl/json_key_value_extractor_top.sv
bench/tb_json_key_value_extractor_top.sv
